// ===== hdl/bnnt_pkg.sv =====
`timescale 1ns / 1ps

package bnnt_pkg;

	// stream payload widths
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned NUM_W   = 11;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TDATA_W = 24;

	// kind codes carried on s_tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_NUMQ  = 2'd1,
		KIND_NAMEQ = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// bit positions inside m_tdata
	localparam int unsigned OUT_NUM_LSB = CHAR_W;
	localparam int unsigned OUT_FOUND   = CHAR_W + NUM_W;

endpackage

// ===== hdl/bnnt_ram.sv =====
`timescale 1ns / 1ps

module bnnt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bidirectional_name_number_table_core.sv =====
`timescale 1ns / 1ps

// Two-way name/number dictionary. Names stream in one character per load
// transaction (kind 0, tlast ends the name) and are numbered 1, 2, ... in load
// order; once CAPACITY names are held further loads are dropped, and characters
// past MAX_NAME_LEN are dropped while tlast still ends the name. A number query
// (kind 1) returns the stored name one character per result transaction
// (tuser=1, found=1, tlast on the final one), or a single number result with
// found=0 for a number of 0 or beyond the loaded count. A name query (kind 2)
// streams the key the same way; the key's tlast transaction yields one number
// result: the earliest entry with the same length and bytes, or found=0 and
// number 0. Kind 3 is ignored. A load or a non-final key character does not
// hold off the input; a number query steps through NMUL and NLEN, then NRD
// and NOUT per character; a name query walks the entries one by one through
// the shared length and name memories (single read port each), checking each
// length, then comparing characters; it grows with the number of loaded names.
// s_tready is low while a query is in progress; one output register lets the
// next transaction be taken while a result waits on m_tready.

module bidirectional_name_number_table_core
	import bnnt_pkg::*;
#(
	parameter int unsigned CAPACITY     = 1024,
	parameter int unsigned MAX_NAME_LEN = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // char_code[7:0], entry_number[18:8], zero pad
	input  logic [KIND_W-1:0]  s_tuser,  // kind[1:0]
	input  logic               s_tlast,  // last_char
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // out_char[7:0], out_number[18:8], found[19], pad
	output logic [0:0]         m_tuser,  // is_name[0]
	output logic               m_tlast   // last
);

	localparam int unsigned ENT_W  = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned STORE_DEPTH = CAPACITY * MAX_NAME_LEN;
	localparam int unsigned NAW    = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
	localparam int unsigned LEN_W  = $clog2(MAX_NAME_LEN + 1);
	localparam int unsigned KP_W   = MAX_NAME_LEN > 1 ? $clog2(MAX_NAME_LEN) : 1;
	localparam int unsigned CMP_W  = CNT_W > NUM_W ? CNT_W : NUM_W;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_NMUL = 10'b0000000010,
		ST_NLEN = 10'b0000000100,
		ST_NRD  = 10'b0000001000,
		ST_NOUT = 10'b0000010000,
		ST_SLEN = 10'b0000100000,
		ST_SCHK = 10'b0001000000,
		ST_SRD  = 10'b0010000000,
		ST_SCMP = 10'b0100000000,
		ST_RES  = 10'b1000000000
	} state_t;

	state_t state_q;

	// input fields
	logic [CHAR_W-1:0] in_char;
	logic [NUM_W-1:0]  in_num;
	kind_t             in_kind;
	logic              in_acc;

	assign in_char = s_tdata[CHAR_W-1:0];
	assign in_num  = s_tdata[CHAR_W +: NUM_W];
	assign in_kind = kind_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc  = s_tvalid && s_tready;

	// dictionary state
	logic [CNT_W-1:0]  entry_count_q;
	logic [LEN_W-1:0]  build_pos_q;
	logic [NAW-1:0]    load_base_q;
	logic [LEN_W-1:0]  key_len_q;
	logic [CHAR_W-1:0] kb_rdata;

	// query working registers; e_q, base_q and pos_q are shared by both query kinds
	logic [CNT_W-1:0]  e_q;       // entry index being read
	logic [NAW-1:0]    base_q;    // name store address of entry e_q
	logic [LEN_W-1:0]  pos_q;     // character position
	logic [LEN_W-1:0]  len_q;     // length of entry for a number query
	logic [LEN_W-1:0]  klen_q;    // length of the key being looked up
	logic [NUM_W-1:0]  res_num_q;
	logic              res_found_q;

	// output register
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] oc_q;
	logic [NUM_W-1:0]  on_q;
	logic              of_q;
	logic              oi_q;
	logic              ol_q;
	logic              slot_free;

	assign slot_free = !m_tvalid_q || m_tready;

	// memories
	logic              st_we;
	logic [NAW-1:0]    st_waddr;
	logic [NAW-1:0]    st_raddr;
	logic [CHAR_W-1:0] st_rdata;
	logic              ln_we;
	logic [LEN_W-1:0]  ln_rdata;
	logic [LEN_W-1:0]  new_build_pos;
	logic              table_full;
	logic              load_acc;

	assign table_full    = (entry_count_q == CNT_W'(CAPACITY));
	assign load_acc      = in_acc && (in_kind == KIND_LOAD) && !table_full;
	assign st_we         = load_acc && (build_pos_q < LEN_W'(MAX_NAME_LEN));
	assign st_waddr      = load_base_q + NAW'(build_pos_q);
	assign ln_we         = load_acc && s_tlast;
	assign new_build_pos = st_we ? build_pos_q + 1'b1 : build_pos_q;
	assign st_raddr      = base_q + NAW'(pos_q);

	bnnt_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (STORE_DEPTH)
	) u_name_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (in_char),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	bnnt_ram #(
		.WIDTH (LEN_W),
		.DEPTH (CAPACITY)
	) u_name_len (
		.clk   (clk),
		.we    (ln_we),
		.waddr (entry_count_q[ENT_W-1:0]),
		.wdata (new_build_pos),
		.raddr (e_q[ENT_W-1:0]),
		.rdata (ln_rdata)
	);

	// number query range check
	logic num_bad;
	assign num_bad = (in_num == '0) ||
		(CMP_W'(in_num) > CMP_W'(entry_count_q));

	// key buffer write
	logic key_we;
	assign key_we = in_acc && (in_kind == KIND_NAMEQ) &&
		(key_len_q < LEN_W'(MAX_NAME_LEN));

	// key buffer, read alongside the name store during a compare
	bnnt_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_NAME_LEN)
	) u_key_buf (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_len_q[KP_W-1:0]),
		.wdata (in_char),
		.raddr (pos_q[KP_W-1:0]),
		.rdata (kb_rdata)
	);

	// emit strobe and payload for the output register
	logic              emit;
	logic [CHAR_W-1:0] emit_char;
	logic [NUM_W-1:0]  emit_num;
	logic              emit_found;
	logic              emit_name;
	logic              emit_last;
	logic              name_last;

	assign name_last = (LEN_W'(pos_q + 1'b1) == len_q);

	always_comb begin
		emit       = 1'b0;
		emit_char  = '0;
		emit_num   = '0;
		emit_found = 1'b0;
		emit_name  = 1'b0;
		emit_last  = 1'b1;
		case (state_q)
			ST_NOUT: begin
				emit       = slot_free;
				emit_char  = st_rdata;
				emit_found = 1'b1;
				emit_name  = 1'b1;
				emit_last  = name_last;
			end
			ST_RES: begin
				emit       = slot_free;
				emit_num   = res_num_q;
				emit_found = res_found_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oc_q <= emit_char;
			on_q <= emit_num;
			of_q <= emit_found;
			oi_q <= emit_name;
			ol_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_W - CHAR_W - NUM_W - 1){1'b0}}, of_q, on_q, oc_q};
	assign m_tuser  = oi_q;
	assign m_tlast  = ol_q;

	// loader and key length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			build_pos_q   <= '0;
			load_base_q   <= '0;
			key_len_q     <= '0;
		end else begin
			if (load_acc) begin
				if (s_tlast) begin
					entry_count_q <= entry_count_q + 1'b1;
					build_pos_q   <= '0;
					load_base_q   <= load_base_q + NAW'(MAX_NAME_LEN);
				end else begin
					build_pos_q <= new_build_pos;
				end
			end
			if (in_acc && in_kind == KIND_NAMEQ) begin
				if (s_tlast) begin
					key_len_q <= '0;
				end else if (key_we) begin
					key_len_q <= key_len_q + 1'b1;
				end
			end
		end
	end

	// sequencer
	logic              key_match;
	assign key_match = (st_rdata == kb_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_kind == KIND_NUMQ) begin
						state_q <= num_bad ? ST_RES : ST_NMUL;
					end else if (in_acc && in_kind == KIND_NAMEQ && s_tlast) begin
						state_q <= ST_SLEN;
					end
				end
				ST_NMUL: state_q <= ST_NLEN;
				ST_NLEN: state_q <= ST_NRD;
				ST_NRD:  state_q <= ST_NOUT;
				ST_NOUT: begin
					if (slot_free) begin
						state_q <= name_last ? ST_IDLE : ST_NRD;
					end
				end
				ST_SLEN: begin
					state_q <= (e_q == entry_count_q) ? ST_RES : ST_SCHK;
				end
				ST_SCHK: begin
					state_q <= (ln_rdata == klen_q) ? ST_SRD : ST_SLEN;
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (!key_match) begin
						state_q <= ST_SLEN;
					end else if (LEN_W'(pos_q + 1'b1) == klen_q) begin
						state_q <= ST_RES;
					end else begin
						state_q <= ST_SRD;
					end
				end
				ST_RES: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_num_q   <= '0;
				res_found_q <= 1'b0;
				pos_q       <= '0;
				base_q      <= '0;
				if (in_kind == KIND_NUMQ) begin
					e_q <= CNT_W'(in_num - 1'b1);
				end else begin
					e_q <= '0;
				end
				klen_q <= key_we ? key_len_q + 1'b1 : key_len_q;
			end
			ST_NMUL: begin
				base_q <= NAW'(e_q * MAX_NAME_LEN);
			end
			ST_NLEN: begin
				len_q <= ln_rdata;
				pos_q <= '0;
			end
			ST_NOUT: begin
				if (slot_free) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			ST_SCHK: begin
				pos_q <= '0;
				if (ln_rdata != klen_q) begin
					e_q    <= e_q + 1'b1;
					base_q <= base_q + NAW'(MAX_NAME_LEN);
				end
			end
			ST_SCMP: begin
				if (!key_match) begin
					e_q    <= e_q + 1'b1;
					base_q <= base_q + NAW'(MAX_NAME_LEN);
				end else if (LEN_W'(pos_q + 1'b1) == klen_q) begin
					res_num_q   <= NUM_W'(e_q + 1'b1);
					res_found_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule

// ===== hdl/bnnt_checker.sv =====
`timescale 1ns / 1ps

module bnnt_checker
	import bnnt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [TDATA_W-1:0] s_tdata,
	input logic [KIND_W-1:0]  s_tuser,
	input logic               s_tlast,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [0:0]         m_tuser,
	input logic               m_tlast
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a load transaction never blocks the next one
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_LOAD |=> s_tready)
		else $error("load held off the input");

	// a number result is always the only and final one of its query
	a_num_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("number result without last");

	// a miss carries zero character and number
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[OUT_FOUND] |-> m_tdata[OUT_FOUND-1:0] == '0)
		else $error("miss with nonzero payload");

	// name characters only come with found set
	a_name_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[OUT_FOUND] && m_tdata[OUT_FOUND-1:OUT_NUM_LSB] == '0)
		else $error("name character with bad flags");

endmodule

bind bidirectional_name_number_table_core bnnt_checker u_bnnt_checker (.*);
